// ===== hw/rtl/compressor_pressure_regulator_unit_assert.svh =====
// Assertion macros for the compressor pressure regulator RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef COMPRESSOR_PRESSURE_REGULATOR_UNIT_ASSERT_SVH
`define COMPRESSOR_PRESSURE_REGULATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CPR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define CPR_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CPR_ASSERT(label, clk, rst_n, prop, msg)
`define CPR_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== hw/rtl/cpr_pkg.sv =====
// Shared types, constants and helpers for the compressor pressure regulator.
// No dependencies; imported by every module of the block.
package cpr_pkg;

	// Tick counter width
	localparam int TIMER_BITS = 20;

	localparam int PRES_W  = 12;
	localparam int HYST_W  = 10;
	localparam int COOL_W  = 20;
	localparam int MODE_W  = 2;
	localparam int CMP_W   = (TIMER_BITS > COOL_W) ? TIMER_BITS : COOL_W;

	// APB register map
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_RUN_PRESSURE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_IDLE_PRESSURE = 3'd1;
	localparam logic [IDX_W-1:0] REG_HYSTERESIS    = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_PRESSURE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_COOL_TICKS    = 3'd4;

	// Reset values
	localparam logic [PRES_W-1:0] RUN_PRESSURE_RST  = 12'd1200;
	localparam logic [PRES_W-1:0] IDLE_PRESSURE_RST = 12'd800;
	localparam logic [HYST_W-1:0] HYSTERESIS_RST    = 10'd50;
	localparam logic [PRES_W-1:0] MAX_PRESSURE_RST  = 12'd1500;
	localparam logic [COOL_W-1:0] COOL_TICKS_RST    = 20'd60000;

	// Run mode codes; the fourth code behaves as off
	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [PRES_W-1:0] pressure;
		logic [MODE_W-1:0] run_mode;
	} sample_t;

	typedef struct packed {
		logic              motor_on;
		logic              in_cooldown;
		logic [MODE_W-1:0] mode_state;
	} result_t;

	typedef struct packed {
		logic [PRES_W-1:0] run_pressure;
		logic [PRES_W-1:0] idle_pressure;
		logic [HYST_W-1:0] hysteresis;
		logic [PRES_W-1:0] max_pressure;
		logic [COOL_W-1:0] cool_ticks;
	} cfg_t;

	// Counter has reached the cool time
	function automatic logic timer_done(logic [TIMER_BITS-1:0] t, logic [COOL_W-1:0] c);
		logic [CMP_W-1:0] te;
		logic [CMP_W-1:0] ce;
		te = CMP_W'(t);
		ce = CMP_W'(c);
		return te >= ce;
	endfunction

endpackage

// ===== hw/rtl/cpr_regs.sv =====
// APB configuration registers of the compressor pressure regulator.
// Depends on cpr_pkg.
module cpr_regs import cpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_pressure  <= RUN_PRESSURE_RST;
			cfg_q.idle_pressure <= IDLE_PRESSURE_RST;
			cfg_q.hysteresis    <= HYSTERESIS_RST;
			cfg_q.max_pressure  <= MAX_PRESSURE_RST;
			cfg_q.cool_ticks    <= COOL_TICKS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_RUN_PRESSURE:  cfg_q.run_pressure  <= pwdata[PRES_W-1:0];
				REG_IDLE_PRESSURE: cfg_q.idle_pressure <= pwdata[PRES_W-1:0];
				REG_HYSTERESIS:    cfg_q.hysteresis    <= pwdata[HYST_W-1:0];
				REG_MAX_PRESSURE:  cfg_q.max_pressure  <= pwdata[PRES_W-1:0];
				REG_COOL_TICKS:    cfg_q.cool_ticks    <= pwdata[COOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_RUN_PRESSURE:  prdata = DATA_W'(cfg_q.run_pressure);
			REG_IDLE_PRESSURE: prdata = DATA_W'(cfg_q.idle_pressure);
			REG_HYSTERESIS:    prdata = DATA_W'(cfg_q.hysteresis);
			REG_MAX_PRESSURE:  prdata = DATA_W'(cfg_q.max_pressure);
			REG_COOL_TICKS:    prdata = DATA_W'(cfg_q.cool_ticks);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/cpr_ctrl.sv =====
// Hysteresis controller: motor, cooldown and tick counter state plus tick logic.
// Depends on cpr_pkg and the assertion macro header.
`include "compressor_pressure_regulator_unit_assert.svh"
module cpr_ctrl import cpr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  sample_t smp,
	input  cfg_t    cfg,
	output result_t res
);

	logic                  run_q;
	logic                  cool_q;
	logic [TIMER_BITS-1:0] ticks_q;

	logic                  run_n;
	logic                  cool_n;
	logic [TIMER_BITS-1:0] ticks_n;
	logic [TIMER_BITS-1:0] ticks_inc;
	logic [MODE_W-1:0]     mode_o;
	logic                  active;
	logic [PRES_W-1:0]     tgt;
	logic [PRES_W:0]       lo_sum;
	logic [PRES_W:0]       hi_sum;
	logic                  start_ok;
	logic                  stop_p;

	// Saturating increment
	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;

	assign active = (smp.run_mode == MODE_RUN) || (smp.run_mode == MODE_IDLE);
	assign tgt    = (smp.run_mode == MODE_IDLE) ? cfg.idle_pressure : cfg.run_pressure;

	// p < tgt - h rewritten as p + h < tgt to stay unsigned
	assign lo_sum   = {1'b0, smp.pressure} + (PRES_W+1)'(cfg.hysteresis);
	assign hi_sum   = {1'b0, tgt} + (PRES_W+1)'(cfg.hysteresis);
	assign start_ok = lo_sum < {1'b0, tgt};
	assign stop_p   = ({1'b0, smp.pressure} >= hi_sum) || (smp.pressure >= cfg.max_pressure);

	// Tick update
	always_comb begin
		run_n   = run_q;
		cool_n  = cool_q;
		ticks_n = ticks_inc;
		mode_o  = MODE_OFF;
		if (active) begin
			mode_o = smp.run_mode;
			if (!run_n && start_ok && !cool_n) begin
				run_n   = 1'b1;
				ticks_n = '0;
			end
			if (run_n) begin
				if (stop_p) begin
					run_n   = 1'b0;
					ticks_n = '0;
				end
				if (timer_done(ticks_n, cfg.cool_ticks)) begin
					run_n   = 1'b0;
					ticks_n = '0;
					cool_n  = 1'b1;
				end
			end
		end else begin
			run_n   = 1'b0;
			ticks_n = '0;
		end
		if (cool_n && timer_done(ticks_n, cfg.cool_ticks)) begin
			cool_n = 1'b0;
		end
	end

	assign res.motor_on    = run_n;
	assign res.in_cooldown = cool_n;
	assign res.mode_state  = mode_o;

	// State registers advance once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cool_q  <= 1'b0;
			ticks_q <= '0;
		end else if (en) begin
			run_q   <= run_n;
			cool_q  <= cool_n;
			ticks_q <= ticks_n;
		end
	end

	// Motor cannot run during the lockout
	`CPR_NEVER(a_run_in_cool, clk, arst_n, run_q && cool_q, "motor running during cooldown")
	// Off mode stops the motor and clears the counter
	`CPR_ASSERT(a_off_clears, clk, arst_n, en && !active |=> !run_q && ticks_q == '0, "off tick left motor or counter")
	// Counter holds when no tick is taken
	`CPR_ASSERT(a_hold, clk, arst_n, !en |=> $stable(ticks_q) && $stable(run_q) && $stable(cool_q), "state moved without a tick")
	// Motor switching always restarts the counter
	`CPR_ASSERT(a_switch_zero, clk, arst_n, en && run_n != run_q |=> ticks_q == '0, "motor switched without counter restart")

endmodule

// ===== hw/rtl/compressor_pressure_regulator_unit.sv =====
// Top level of the compressor pressure regulator: handshakes and pipeline registers.
// Depends on cpr_pkg, cpr_regs, cpr_ctrl and the assertion macro header.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample) carries one request per
//   millisecond tick: a pressure sample and a run mode.
//   result channel (result_valid/result_ready/result) returns one result per
//   request: motor drive, cooldown lockout and the echoed mode.
//   APB port configures run/idle pressure, hysteresis, max pressure and cool
//   time; pready is always high, writes should be made while the block is idle.
// Path: an accepted request is held in the input register, then moves to the result register.
// Throughput: one request per cycle while result_ready is high; the tick logic is a single
// compare and counter step between the input register and the result register.
// Reset: motor off, no cooldown, counter zero, registers at their defaults;
// no clearing pass, sample_ready is high as soon as reset is released.
// Stall: while the result waits, the input register still takes one more
// request; sample_ready drops only once both registers are full.
`include "compressor_pressure_regulator_unit_assert.svh"
module compressor_pressure_regulator_unit import cpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	sample_t smp_s1;
	logic    vld_s1;
	logic    adv_s1;
	result_t res_n;
	result_t res_s2;
	logic    vld_s2;

	cpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.smp    (smp_s1),
		.cfg    (cfg),
		.res    (res_n)
	);

	// Flow control
	assign adv_s1       = vld_s1 && (!vld_s2 || result_ready);
	assign sample_ready = !vld_s1 || adv_s1;
	assign result_valid = vld_s2;
	assign result       = res_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample_ready) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			smp_s1 <= sample;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (result_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_n;
		end
	end

	// Backpressure only when both registers hold a request
	`CPR_ASSERT(a_ready, clk, arst_n, !sample_ready |-> vld_s1 && vld_s2 && !result_ready, "ready low without full pipe")
	// A stalled result is not overwritten
	`CPR_ASSERT(a_no_overrun, clk, arst_n, vld_s2 && !result_ready |-> !adv_s1, "result overwritten while stalled")
	// Echoed mode is a defined code
	`CPR_ASSERT(a_mode_code, clk, arst_n, vld_s2 |-> res_s2.mode_state != MODE_SPARE, "invalid mode in result")

endmodule

// ===== tb/tb_top.sv =====
// Testbench for compressor_pressure_regulator_unit: directed table, then random tick sequences.
// Each result is checked against a fixed table expectation or a behavioral model of the controller kept in this file.
// Depends on cpr_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
	import cpr_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int GAP_PCT = 31;
	localparam int SHOWN_FAILURES = 10;
	localparam int PLAN_LEN = 33;
	localparam int PHASES = 8;

	typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

	// One row of the directed table: a register write or a request
	typedef struct packed {
		row_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [COOL_W-1:0] value;
		sample_t           tick;
		logic              fixed;
		result_t           want;
	} plan_row_t;

	typedef struct packed {
		sample_t tick;
		logic    fixed;
		result_t want;
	} queued_tick_t;

	// want is only used where fixed is set; other rows go through the model
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// reset settings: off and the spare mode force the motor off
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd4095, MODE_OFF}, 1'b1, '{1'b0, 1'b0, MODE_OFF}},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_SPARE}, 1'b1, '{1'b0, 1'b0, MODE_OFF}},
		// empty tank starts the motor, band edges stop it
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b1, '{1'b1, 1'b0, MODE_RUN}},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd1249, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd1250, MODE_RUN}, 1'b1, '{1'b0, 1'b0, MODE_RUN}},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd1149, MODE_IDLE}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd749, MODE_IDLE}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd4095, MODE_RUN}, 1'b1, '{1'b0, 1'b0, MODE_RUN}},
		// max pressure under the start threshold: start and stop in one tick
		'{ROW_CFG, REG_MAX_PRESSURE, 20'd0, '0, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b1, '{1'b0, 1'b0, MODE_RUN}},
		// target under hysteresis: motor never starts
		'{ROW_CFG, REG_MAX_PRESSURE, 20'd4095, '0, 1'b0, '0},
		'{ROW_CFG, REG_HYSTERESIS, 20'd1023, '0, 1'b0, '0},
		'{ROW_CFG, REG_RUN_PRESSURE, 20'd1000, '0, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b1, '{1'b0, 1'b0, MODE_RUN}},
		// top target, no band, zero idle target
		'{ROW_CFG, REG_RUN_PRESSURE, 20'd4095, '0, 1'b0, '0},
		'{ROW_CFG, REG_HYSTERESIS, 20'd0, '0, 1'b0, '0},
		'{ROW_CFG, REG_IDLE_PRESSURE, 20'd0, '0, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd4095, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd4094, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_IDLE}, 1'b0, '0},
		// zero cool time: stop, lockout and release all in one tick
		'{ROW_CFG, REG_COOL_TICKS, 20'd0, '0, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b1, '{1'b0, 1'b0, MODE_RUN}},
		// short cool time: run-time stop, lockout across an off tick, restart
		'{ROW_CFG, REG_COOL_TICKS, 20'd3, '0, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_OFF}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0},
		'{ROW_TICK, REG_RUN_PRESSURE, '0, '{12'd0, MODE_RUN}, 1'b0, '0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	sample_t           sample = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Model state and settings
	cfg_t                  cfg;
	logic                  motor_q;
	logic                  cool_q;
	logic [TIMER_BITS-1:0] timer_q;

	queued_tick_t tick_backlog[$];
	result_t      due_results[$];
	queued_tick_t in_flight;
	result_t      predicted;
	result_t      due;
	int           errors;
	bit           no_gaps;

	compressor_pressure_regulator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic void flag(string msg);
		errors++;
		if (errors <= SHOWN_FAILURES) begin
			$display("%s", msg);
		end
	endfunction

	function automatic logic [PRES_W-1:0] clip_pressure(int p);
		if (p < 0) begin
			return '0;
		end
		if (p > 4095) begin
			return '1;
		end
		return p[PRES_W-1:0];
	endfunction

	// One millisecond tick of the hysteresis controller
	function automatic result_t regulate_tick(sample_t s);
		int      p;
		int      tgt;
		int      h;
		result_t r;
		p = s.pressure;
		r.mode_state = MODE_OFF;
		if (timer_q != '1) begin
			timer_q = timer_q + 1'b1;
		end
		if (s.run_mode == MODE_RUN || s.run_mode == MODE_IDLE) begin
			tgt = (s.run_mode == MODE_IDLE) ? cfg.idle_pressure : cfg.run_pressure;
			h = cfg.hysteresis;
			r.mode_state = s.run_mode;
			if (!motor_q && p < tgt - h && !cool_q) begin
				motor_q = 1'b1;
				timer_q = '0;
			end
			if (motor_q) begin
				if (p >= tgt + h || p >= int'(cfg.max_pressure)) begin
					motor_q = 1'b0;
					timer_q = '0;
				end
				// run-time limit applies even right after a pressure stop
				if (timer_q >= cfg.cool_ticks) begin
					motor_q = 1'b0;
					timer_q = '0;
					cool_q = 1'b1;
				end
			end
		end else begin
			motor_q = 1'b0;
			timer_q = '0;
		end
		if (cool_q && timer_q >= cfg.cool_ticks) begin
			cool_q = 1'b0;
		end
		r.motor_on = motor_q;
		r.in_cooldown = cool_q;
		return r;
	endfunction

	task automatic queue_tick(sample_t tick, logic fixed, result_t want);
		tick_backlog.push_back('{tick, fixed, want});
	endtask

	// Register write, then read back
	task automatic apb_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] readback;
		readback = '0;
		case (idx)
			REG_RUN_PRESSURE: begin
				cfg.run_pressure = value[PRES_W-1:0];
				readback = DATA_W'(cfg.run_pressure);
			end
			REG_IDLE_PRESSURE: begin
				cfg.idle_pressure = value[PRES_W-1:0];
				readback = DATA_W'(cfg.idle_pressure);
			end
			REG_HYSTERESIS: begin
				cfg.hysteresis = value[HYST_W-1:0];
				readback = DATA_W'(cfg.hysteresis);
			end
			REG_MAX_PRESSURE: begin
				cfg.max_pressure = value[PRES_W-1:0];
				readback = DATA_W'(cfg.max_pressure);
			end
			REG_COOL_TICKS: begin
				cfg.cool_ticks = value[COOL_W-1:0];
				readback = DATA_W'(cfg.cool_ticks);
			end
			default: begin
			end
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		// write lands here; turn straight into a read setup
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== readback) begin
			flag($sformatf("reg %0d readback: exp %0h got %0h", idx, readback, prdata));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Block idle: nothing queued, nothing offered, nothing outstanding
	task automatic wait_idle();
		@(negedge clk);
		while (tick_backlog.size() != 0 || sample_valid || due_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	// Pump-up, leak-down and hover sequences around the band, plus noise
	task automatic queue_random_ticks(int count);
		int               made;
		int               len;
		int               p;
		int               tgt;
		int               h;
		int               stepmax;
		int               shape;
		logic [MODE_W-1:0] mode;
		logic [MODE_W-1:0] m;
		made = 0;
		p = 0;
		while (made < count) begin
			shape = $urandom_range(0, 9);
			mode = $urandom_range(0, 1) ? MODE_RUN : MODE_IDLE;
			tgt = (mode == MODE_IDLE) ? cfg.idle_pressure : cfg.run_pressure;
			h = cfg.hysteresis;
			len = $urandom_range(5, 60);
			stepmax = $urandom_range(1, 2 + h / 10);
			if (shape <= 5) begin
				p = tgt - h - int'($urandom_range(1, 40));
			end else if (shape <= 7) begin
				p = tgt + h + int'($urandom_range(0, 40));
			end else if (shape == 8) begin
				len = $urandom_range(1, 10);
			end
			for (int i = 0; i < len; i++) begin
				if (shape <= 5) begin
					m = ($urandom_range(0, 39) == 0) ? MODE_OFF : mode;
					queue_tick('{clip_pressure(p), m}, 1'b0, '0);
					p = p + int'($urandom_range(0, stepmax));
				end else if (shape <= 7) begin
					queue_tick('{clip_pressure(p), mode}, 1'b0, '0);
					p = p - int'($urandom_range(0, stepmax));
				end else if (shape == 8) begin
					queue_tick('{PRES_W'($urandom_range(0, 4095)), MODE_W'($urandom_range(0, 3))},
						1'b0, '0);
				end else begin
					m = ($urandom_range(0, 7) == 0) ? MODE_OFF : mode;
					p = tgt - h - 3 + int'($urandom_range(0, 2 * h + 6));
					queue_tick('{clip_pressure(p), m}, 1'b0, '0);
				end
				made++;
			end
		end
	endtask

	// Request side: predict on acceptance, then offer the next tick or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
		end else begin
			if (sample_valid && sample_ready) begin
				predicted = regulate_tick(sample);
				due_results.push_back(in_flight.fixed ? in_flight.want : predicted);
			end
			if (!sample_valid || sample_ready) begin
				if (tick_backlog.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
					in_flight = tick_backlog.pop_front();
					sample <= in_flight.tick;
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Result side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (due_results.size() == 0) begin
				flag($sformatf("unexpected result %b/%b/%0d",
					result.motor_on, result.in_cooldown, result.mode_state));
			end else begin
				due = due_results.pop_front();
				if (result.motor_on !== due.motor_on || result.in_cooldown !== due.in_cooldown ||
					result.mode_state !== due.mode_state) begin
					flag($sformatf("result: motor exp %b got %b, cooldown exp %b got %b, mode exp %0d got %0d",
						due.motor_on, result.motor_on, due.in_cooldown, result.in_cooldown,
						due.mode_state, result.mode_state));
				end
			end
		end
	end

	initial begin
		int run_p;
		int idle_p;
		int hyst;
		int max_p;
		int cool;
		errors = 0;
		no_gaps = 1'b0;
		cfg = '{RUN_PRESSURE_RST, IDLE_PRESSURE_RST, HYSTERESIS_RST, MAX_PRESSURE_RST,
			COOL_TICKS_RST};
		motor_q = 1'b0;
		cool_q = 1'b0;
		timer_q = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				wait_idle();
				apb_write(PLAN[i].idx, DATA_W'(PLAN[i].value));
			end else begin
				queue_tick(PLAN[i].tick, PLAN[i].fixed, PLAN[i].want);
			end
		end

		// Random phases, each under fresh settings; first two at the extremes
		for (int k = 0; k < PHASES; k++) begin
			if (k == 0) begin
				run_p = 4095;
				idle_p = 4095;
				hyst = 1023;
				max_p = 4095;
				cool = 1048575;
			end else if (k == 1) begin
				run_p = 0;
				idle_p = 0;
				hyst = 0;
				max_p = 0;
				cool = 1;
			end else begin
				run_p = $urandom_range(100, 4000);
				idle_p = $urandom_range(100, 4000);
				hyst = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 150);
				max_p = (run_p > idle_p) ? run_p : idle_p;
				max_p = ($urandom_range(0, 9) < 7) ? max_p + hyst + int'($urandom_range(0, 300))
					: $urandom_range(0, 4095);
				if (max_p > 4095) begin
					max_p = 4095;
				end
				cool = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40) : $urandom_range(41, 400);
			end
			wait_idle();
			no_gaps = (k == 4);
			apb_write(REG_RUN_PRESSURE, run_p);
			apb_write(REG_IDLE_PRESSURE, idle_p);
			apb_write(REG_HYSTERESIS, hyst);
			apb_write(REG_MAX_PRESSURE, max_p);
			apb_write(REG_COOL_TICKS, cool);
			queue_random_ticks((k == 1) ? 60 : 160);
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
